FILE: hw/rtl/pngisw_pkg.sv
`default_nettype none

package pngisw_pkg;

  localparam int DIM_W   = 31;
  localparam int DEPTH_W = 5;
  localparam int KIND_W  = 8;
  localparam int BPP_W   = 7;
  localparam int BITS_W  = DIM_W + BPP_W;
  localparam int RL_W    = 30;
  localparam int PROD_W  = DIM_W + RL_W;
  localparam int TERM_W  = 32;
  localparam int PSUM_W  = TERM_W + 1;
  localparam int BYTES_W = 35;
  localparam int WIN_W   = 4;
  localparam int LANES   = 7;
  localparam int STAGES  = 7;

  localparam logic [KIND_W-1:0] COLOUR_GREY       = 8'd0;
  localparam logic [KIND_W-1:0] COLOUR_RGB        = 8'd2;
  localparam logic [KIND_W-1:0] COLOUR_PALETTE    = 8'd3;
  localparam logic [KIND_W-1:0] COLOUR_GREY_ALPHA = 8'd4;
  localparam logic [KIND_W-1:0] COLOUR_RGBA       = 8'd6;

  localparam logic [KIND_W-1:0] ILACE_NONE  = 8'd0;
  localparam logic [KIND_W-1:0] ILACE_ADAM7 = 8'd1;

  localparam logic [BYTES_W-1:0] WIN_T15 = 35'd16384;
  localparam logic [BYTES_W-1:0] WIN_T14 = 35'd8192;
  localparam logic [BYTES_W-1:0] WIN_T13 = 35'd4096;
  localparam logic [BYTES_W-1:0] WIN_T12 = 35'd2048;
  localparam logic [BYTES_W-1:0] WIN_T11 = 35'd1024;
  localparam logic [BYTES_W-1:0] WIN_T10 = 35'd512;
  localparam logic [BYTES_W-1:0] WIN_T9  = 35'd256;
  localparam logic [WIN_W-1:0]   WIN_MIN = 4'd8;

  // Adam7 pass geometry
  localparam logic [2:0] COL_START [LANES] = '{3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0};
  localparam logic [1:0] COL_SHIFT [LANES] = '{2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};
  localparam logic [2:0] ROW_START [LANES] = '{3'd0, 3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd1};
  localparam logic [1:0] ROW_SHIFT [LANES] = '{2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1};

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_BAD_COLOUR    = 2'd1,
    ST_BAD_INTERLACE = 2'd2,
    ST_OVERFLOW      = 2'd3
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [DEPTH_W-1:0] sample_depth;
    logic [KIND_W-1:0]  colour_kind;
    logic [KIND_W-1:0]  interlace_kind;
  } hdr_t;

  typedef struct packed {
    logic [BYTES_W-1:0] data_bytes;
    logic [WIN_W-1:0]   window_bits;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic mul;
    logic len;
    logic prod;
  } lane_en_t;

  function automatic logic [DIM_W-1:0] pass_count(input logic [DIM_W-1:0] n,
                                                  input logic [2:0] start,
                                                  input logic [1:0] shift);
    logic [DIM_W:0] s;
    s = {1'b0, n} + (({{DIM_W{1'b0}}, 1'b1} << shift) - {{DIM_W{1'b0}}, 1'b1})
        - {{(DIM_W-2){1'b0}}, start};
    return DIM_W'(s >> shift);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/png_image_size_window_bits.sv
`default_nettype none

// Filtered PNG image data size and deflate window selector. Each header beat
// gives one result beat: the byte count of the filtered image data (filter
// bytes included, plain or Adam7), the smallest window log2 from 8 to 15 that
// covers it (15 for larger counts), and a status. Takes one header per cycle
// unless the output stalls; the seven lanes (one per Adam7 pass) each run a
// column times bits-per-pixel multiply and a rows times row-length multiply
// in their own stages, and a two-stage adder tree sums them. Stages with no
// valid beat still take new work while a result waits at the output.
module png_image_size_window_bits import pngisw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic hdr_valid,
  output logic hdr_ready,
  input  hdr_t hdr,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic [STAGES:1] vld;
  logic [STAGES:1] adv;

  always_comb begin
    adv[STAGES] = !vld[STAGES] || res_ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign hdr_ready = adv[1];
  assign res_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= hdr_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // header decode
  logic [BPP_W-1:0] bpp_in;
  status_t          st_in;
  logic [DIM_W-1:0] cols_in [LANES];
  logic [DIM_W-1:0] rows_in [LANES];
  logic [LANES-1:0] use_in;

  always_comb begin
    st_in  = ST_OK;
    bpp_in = '0;
    case (hdr.colour_kind)
      COLOUR_GREY, COLOUR_PALETTE: bpp_in = BPP_W'(hdr.sample_depth);
      COLOUR_RGB:        bpp_in = BPP_W'(hdr.sample_depth) * BPP_W'(3);
      COLOUR_GREY_ALPHA: bpp_in = BPP_W'(hdr.sample_depth) * BPP_W'(2);
      COLOUR_RGBA:       bpp_in = BPP_W'(hdr.sample_depth) * BPP_W'(4);
      default:           st_in  = ST_BAD_COLOUR;
    endcase
    if (st_in == ST_OK && hdr.interlace_kind != ILACE_NONE &&
        hdr.interlace_kind != ILACE_ADAM7) begin
      st_in = ST_BAD_INTERLACE;
    end
    for (int p = 0; p < LANES; p++) begin
      if (hdr.interlace_kind == ILACE_ADAM7) begin
        cols_in[p] = pass_count(hdr.image_width, COL_START[p], COL_SHIFT[p]);
        rows_in[p] = pass_count(hdr.image_height, ROW_START[p], ROW_SHIFT[p]);
        use_in[p]  = cols_in[p] != '0;
      end else begin
        cols_in[p] = (p == 0) ? hdr.image_width : '0;
        rows_in[p] = (p == 0) ? hdr.image_height : '0;
        use_in[p]  = (p == 0);
      end
    end
  end

  logic [BPP_W-1:0] bpp1;
  logic [DIM_W-1:0] cols1 [LANES];
  logic [DIM_W-1:0] rows1 [LANES];
  logic [LANES-1:0] use1;
  status_t          st_p [1:STAGES-1];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      bpp1     <= bpp_in;
      cols1    <= cols_in;
      rows1    <= rows_in;
      use1     <= use_in;
      st_p[1]  <= st_in;
    end
    for (int k = 2; k <= STAGES - 1; k++) begin
      if (adv[k]) st_p[k] <= st_p[k-1];
    end
  end

  lane_en_t          lane_en;
  logic [TERM_W-1:0] term4 [LANES];
  logic [LANES-1:0]  ovf4;

  assign lane_en = '{mul: adv[2], len: adv[3], prod: adv[4]};

  for (genvar p = 0; p < LANES; p++) begin : g_lane
    pngisw_lane u_lane (
      .clk    (clk),
      .en     (lane_en),
      .bpp    (bpp1),
      .cols   (cols1[p]),
      .rows   (rows1[p]),
      .use_in (use1[p]),
      .term   (term4[p]),
      .ovf    (ovf4[p])
    );
  end

  // adder tree
  logic [PSUM_W-1:0]  psum5 [4];
  logic               ovf5;
  logic [BYTES_W-1:0] total6;
  logic               ovf6;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      psum5[0] <= PSUM_W'(term4[0]) + PSUM_W'(term4[1]);
      psum5[1] <= PSUM_W'(term4[2]) + PSUM_W'(term4[3]);
      psum5[2] <= PSUM_W'(term4[4]) + PSUM_W'(term4[5]);
      psum5[3] <= PSUM_W'(term4[6]);
      ovf5     <= |ovf4;
    end
    if (adv[6]) begin
      total6 <= BYTES_W'(psum5[0]) + BYTES_W'(psum5[1])
              + BYTES_W'(psum5[2]) + BYTES_W'(psum5[3]);
      ovf6   <= ovf5;
    end
  end

  // result
  status_t          st_fin;
  logic [WIN_W-1:0] win;

  always_comb begin
    if (st_p[STAGES-1] != ST_OK) st_fin = st_p[STAGES-1];
    else if (ovf6)               st_fin = ST_OVERFLOW;
    else                         st_fin = ST_OK;
    if (total6 > WIN_T15)      win = 4'd15;
    else if (total6 > WIN_T14) win = 4'd14;
    else if (total6 > WIN_T13) win = 4'd13;
    else if (total6 > WIN_T12) win = 4'd12;
    else if (total6 > WIN_T11) win = 4'd11;
    else if (total6 > WIN_T10) win = 4'd10;
    else if (total6 > WIN_T9)  win = 4'd9;
    else                       win = WIN_MIN;
  end

  always_ff @(posedge clk) begin
    if (adv[STAGES]) begin
      res.status <= st_fin;
      if (st_fin == ST_OK) begin
        res.data_bytes  <= total6;
        res.window_bits <= win;
      end else begin
        res.data_bytes  <= '0;
        res.window_bits <= WIN_MIN;
      end
    end
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.data_bytes == '0 && res.window_bits == WIN_MIN)
    else $error("error result carries a byte count");

  a_win_large: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_OK && res.data_bytes > WIN_T15 |-> res.window_bits == 4'd15)
    else $error("window too small for byte count");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/pngisw_lane.sv
`default_nettype none

module pngisw_lane import pngisw_pkg::*; (
  input  logic              clk,
  input  lane_en_t          en,
  input  logic [BPP_W-1:0]  bpp,
  input  logic [DIM_W-1:0]  cols,
  input  logic [DIM_W-1:0]  rows,
  input  logic              use_in,
  output logic [TERM_W-1:0] term,
  output logic              ovf
);

  logic [BITS_W-1:0] bits_a;
  logic [DIM_W-1:0]  rows_a;
  logic              use_a;
  logic [RL_W-1:0]   rl_b;
  logic [DIM_W-1:0]  rows_b;
  logic              ovf_b;
  logic              use_b;
  logic [TERM_W:0]   sum_b;
  logic [PROD_W-1:0] prod_c;

  // bytes per row incl. filter byte; only meaningful when bits fit 32
  assign sum_b  = {1'b0, bits_a[TERM_W-1:0]} + (TERM_W+1)'(7);
  assign prod_c = PROD_W'(rows_b) * PROD_W'(rl_b);

  always_ff @(posedge clk) begin
    if (en.mul) begin
      bits_a <= BITS_W'(cols) * BITS_W'(bpp);
      rows_a <= rows;
      use_a  <= use_in;
    end
    if (en.len) begin
      rl_b   <= sum_b[TERM_W:3] + RL_W'(1);
      ovf_b  <= |bits_a[BITS_W-1:TERM_W];
      rows_b <= rows_a;
      use_b  <= use_a;
    end
    if (en.prod) begin
      if (use_b) begin
        term <= prod_c[TERM_W-1:0];
        ovf  <= ovf_b | (|prod_c[PROD_W-1:TERM_W]);
      end else begin
        term <= '0;
        ovf  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
